// ===== sv/apl_pkg.sv =====
// ----------------------------------------------------------------------------
// apl_pkg: shared constants for the audio peak limiter
// Field widths, fixed-point constants, register indexes and reset values.
// ----------------------------------------------------------------------------
package apl_pkg;

   localparam int MAX_CHANNELS = 2;

   localparam int SAMPLE_W = 24;
   localparam int LEVEL_W  = 23;
   localparam int GAIN_W   = 17;
   localparam int COEFF_W  = 24;
   localparam int CHAN_W   = 2;
   localparam int MCAND_W  = 25;
   localparam int PROD_W   = MCAND_W + GAIN_W;
   localparam int DIVH_W   = 20;
   localparam int STEPS    = GAIN_W;
   localparam int STEP_W   = 5;
   localparam int REQ_W    = 2 * SAMPLE_W;
   localparam int RSP_W    = 2 * SAMPLE_W + 2 * GAIN_W + 2 * LEVEL_W;

   localparam logic [GAIN_W-1:0]  UNITY_GAIN    = GAIN_W'(65536);
   localparam logic [CHAN_W-1:0]  CHAN_RESET    = CHAN_W'(2);
   localparam logic [GAIN_W-1:0]  CEILING_RESET = GAIN_W'(58982);
   localparam logic [COEFF_W-1:0] COEFF_RESET   = COEFF_W'(2330);

   localparam logic [1:0] REG_ACTIVE_CHANNELS = 2'd0;
   localparam logic [1:0] REG_CEILING         = 2'd1;
   localparam logic [1:0] REG_RELEASE_COEFF   = 2'd2;

endpackage

// ===== sv/apl_serial_mul.sv =====
// ----------------------------------------------------------------------------
// apl_serial_mul: bit-serial multiplier
// Signed multiplicand times unsigned gain-width multiplier, one multiplier
// bit per cycle, MSB first. done pulses once the product is in place.
// ----------------------------------------------------------------------------
module apl_serial_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [apl_pkg::MCAND_W-1:0]  mcand,
   input  logic        [apl_pkg::GAIN_W-1:0]   mplr,
   output logic                                done,
   output logic signed [apl_pkg::PROD_W-1:0]   product
);

   logic                                busy_ff;
   logic                                done_ff;
   logic        [apl_pkg::STEP_W-1:0]   cnt_ff;
   logic signed [apl_pkg::MCAND_W-1:0]  mcand_ff;
   logic        [apl_pkg::GAIN_W-1:0]   mplr_ff;
   logic signed [apl_pkg::PROD_W-1:0]   acc_ff;
   logic signed [apl_pkg::PROD_W-1:0]   acc_in;
   logic signed [apl_pkg::PROD_W-1:0]   addend;

   always_comb begin
      addend = mplr_ff[apl_pkg::GAIN_W-1] ? apl_pkg::PROD_W'(mcand_ff) : '0;
      acc_in = (acc_ff <<< 1) + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= apl_pkg::STEP_W'(apl_pkg::STEPS - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= mcand;
         mplr_ff  <= mplr;
         acc_ff   <= '0;
      end else if (busy_ff) begin
         mplr_ff <= {mplr_ff[apl_pkg::GAIN_W-2:0], 1'b0};
         acc_ff  <= acc_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== sv/apl_serial_div.sv =====
// ----------------------------------------------------------------------------
// apl_serial_div: bit-serial restoring divider
// Produces a gain-width quotient one bit per cycle. The partial remainder
// is loaded already shifted, so it must start below the divisor.
// ----------------------------------------------------------------------------
module apl_serial_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [apl_pkg::DIVH_W-1:0]     dividend_hi,
   input  logic [apl_pkg::LEVEL_W-1:0]    divisor,
   output logic                           done,
   output logic [apl_pkg::GAIN_W-1:0]     quotient
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [apl_pkg::STEP_W-1:0]    cnt_ff;
   logic [apl_pkg::LEVEL_W-1:0]   dv_ff;
   logic [apl_pkg::LEVEL_W-1:0]   rem_ff;
   logic [apl_pkg::GAIN_W-1:0]    quo_ff;
   logic [apl_pkg::LEVEL_W:0]     trial;
   logic [apl_pkg::LEVEL_W:0]     diff;
   logic                          ge;

   always_comb begin
      trial = {rem_ff, 1'b0};
      diff  = trial - {1'b0, dv_ff};
      ge    = (trial >= {1'b0, dv_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= apl_pkg::STEP_W'(apl_pkg::STEPS - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dv_ff  <= divisor;
         rem_ff <= apl_pkg::LEVEL_W'(dividend_hi);
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[apl_pkg::LEVEL_W-1:0] : trial[apl_pkg::LEVEL_W-1:0];
         quo_ff <= {quo_ff[apl_pkg::GAIN_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/audio_peak_limiter_top.sv =====
// ----------------------------------------------------------------------------
// audio_peak_limiter_top: output peak limiter, instant attack, exp. release
// One request is one audio frame; one response carries the limited samples,
// the gain used and the three meters.
// ----------------------------------------------------------------------------
// Per frame, one bit-serial multiplier runs the release, the attack test,
// one scaling per active channel and the post level in turn, and the
// 17-step serial divider adds its pass only on frames where the attack
// fires. One frame is in flight at a time; a finished response waits in its
// own register while the next request is taken. Configuration writes are
// accepted in every cycle.
module audio_peak_limiter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [apl_pkg::REQ_W-1:0]         req_tdata,  // sample_a, sample_b
   input  logic [0:0]                        req_tuser,  // clear_meters
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_a, out_b, applied_gain, out_peak, in_peak, min_gain
   output logic [apl_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [apl_pkg::COEFF_W-1:0]       csr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_REL  = 3'd1;
   localparam logic [2:0] ST_ATK  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_SCA  = 3'd4;
   localparam logic [2:0] ST_SCB  = 3'd5;
   localparam logic [2:0] ST_PST  = 3'd6;
   localparam logic [2:0] ST_FIN  = 3'd7;

   function automatic logic [apl_pkg::LEVEL_W-1:0] mag(
      input logic [apl_pkg::SAMPLE_W-1:0] x
   );
      logic [apl_pkg::SAMPLE_W-1:0] neg;
      neg = ~x + 1'b1;
      if (!x[apl_pkg::SAMPLE_W-1])
         return x[apl_pkg::LEVEL_W-1:0];
      else if (neg[apl_pkg::SAMPLE_W-1])
         return '1;
      else
         return neg[apl_pkg::LEVEL_W-1:0];
   endfunction

   logic [2:0]                       state_ff, state_in;
   logic                             launch_ff, launch_in;
   logic [apl_pkg::CHAN_W-1:0]       chan_ff, chan_in;
   logic [apl_pkg::GAIN_W-1:0]       ceil_ff, ceil_in;
   logic [apl_pkg::COEFF_W-1:0]      coeff_ff, coeff_in;
   logic [apl_pkg::GAIN_W-1:0]       gain_ff, gain_in;
   logic [apl_pkg::LEVEL_W-1:0]      pre_ff, pre_in;
   logic [apl_pkg::LEVEL_W-1:0]      post_ff, post_in;
   logic [apl_pkg::GAIN_W-1:0]       floor_ff, floor_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             two_ff, two_in;
   logic [apl_pkg::SAMPLE_W-1:0]     sa_ff, sa_in;
   logic [apl_pkg::SAMPLE_W-1:0]     sb_ff, sb_in;
   logic [apl_pkg::LEVEL_W-1:0]      level_ff, level_in;
   logic [apl_pkg::SAMPLE_W-1:0]     oa_ff, oa_in;
   logic [apl_pkg::SAMPLE_W-1:0]     ob_ff, ob_in;
   logic [apl_pkg::RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   logic                             mul_start, mul_done;
   logic signed [apl_pkg::MCAND_W-1:0] mul_mcand;
   logic [apl_pkg::GAIN_W-1:0]       mul_mplr;
   logic signed [apl_pkg::PROD_W-1:0] mul_prod;
   logic [apl_pkg::PROD_W-1:0]       prod_u;
   logic [apl_pkg::PROD_W-1:0]       rel_sum;
   logic [apl_pkg::PROD_W-1:0]       rnd;
   logic [apl_pkg::PROD_W-1:0]       lim;
   logic [apl_pkg::LEVEL_W-1:0]      post_lvl;
   logic                             div_start, div_done;
   logic [apl_pkg::GAIN_W-1:0]       div_q;
   logic                             two_eff;
   logic [apl_pkg::LEVEL_W-1:0]      mag_a, mag_b;
   logic [apl_pkg::SAMPLE_W-1:0]     req_a, req_b;

   assign req_a   = req_tdata[apl_pkg::SAMPLE_W-1:0];
   assign req_b   = req_tdata[apl_pkg::REQ_W-1:apl_pkg::SAMPLE_W];
   assign two_eff = (apl_pkg::MAX_CHANNELS >= 2) && (chan_ff >= apl_pkg::CHAN_W'(2));
   assign mag_a   = mag(req_a);
   assign mag_b   = two_eff ? mag(req_b) : '0;

   assign prod_u   = mul_prod;
   assign rel_sum  = prod_u + (apl_pkg::PROD_W'(1) << 23);
   assign rnd      = prod_u + apl_pkg::PROD_W'(32768);
   assign lim      = apl_pkg::PROD_W'({ceil_ff, 20'b0});
   assign post_lvl = (rnd[40:39] != 2'b00) ? '1 : rnd[38:16];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // multiplier operand select
   always_comb begin
      mul_mcand = '0;
      mul_mplr  = gain_ff;
      case (state_ff)
         ST_REL: begin
            mul_mcand = $signed({1'b0, coeff_ff});
            mul_mplr  = apl_pkg::UNITY_GAIN - gain_ff;
         end
         ST_ATK, ST_PST: mul_mcand = $signed({2'b00, level_ff});
         ST_SCA: mul_mcand = $signed({sa_ff[apl_pkg::SAMPLE_W-1], sa_ff});
         ST_SCB: mul_mcand = $signed({sb_ff[apl_pkg::SAMPLE_W-1], sb_ff});
         default: mul_mcand = '0;
      endcase
      mul_start = launch_ff && (state_ff == ST_REL || state_ff == ST_ATK ||
                                state_ff == ST_SCA || state_ff == ST_SCB ||
                                state_ff == ST_PST);
      div_start = launch_ff && (state_ff == ST_DIV);
   end

   always_comb begin
      state_in     = state_ff;
      launch_in    = 1'b0;
      chan_in      = chan_ff;
      ceil_in      = ceil_ff;
      coeff_in     = coeff_ff;
      gain_in      = gain_ff;
      pre_in       = pre_ff;
      post_in      = post_ff;
      floor_in     = floor_ff;
      rsp_valid_in = rsp_valid_ff;
      two_in       = two_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      level_in     = level_ff;
      oa_in        = oa_ff;
      ob_in        = ob_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         case (csr_index)
            apl_pkg::REG_ACTIVE_CHANNELS: chan_in = csr_data[apl_pkg::CHAN_W-1:0];
            apl_pkg::REG_CEILING:         ceil_in = csr_data[apl_pkg::GAIN_W-1:0];
            apl_pkg::REG_RELEASE_COEFF:   coeff_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sa_in    = req_a;
               sb_in    = req_b;
               two_in   = two_eff;
               level_in = (mag_b > mag_a) ? mag_b : mag_a;
               if (req_tuser[0]) begin
                  pre_in   = (mag_b > mag_a) ? mag_b : mag_a;
                  post_in  = '0;
                  floor_in = apl_pkg::UNITY_GAIN;
               end else begin
                  pre_in = (mag_a > pre_ff) ? mag_a : pre_ff;
                  if (mag_b > pre_in)
                     pre_in = mag_b;
               end
               state_in  = ST_REL;
               launch_in = 1'b1;
            end
         end
         ST_REL: begin
            if (mul_done) begin
               gain_in   = gain_ff + rel_sum[40:24];
               state_in  = ST_ATK;
               launch_in = 1'b1;
            end
         end
         ST_ATK: begin
            if (mul_done) begin
               state_in  = (prod_u > lim) ? ST_DIV : ST_SCA;
               launch_in = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               gain_in   = div_q;
               state_in  = ST_SCA;
               launch_in = 1'b1;
            end
         end
         ST_SCA: begin
            if (mul_done) begin
               oa_in     = rnd[39:16];
               ob_in     = '0;
               state_in  = two_ff ? ST_SCB : ST_PST;
               launch_in = 1'b1;
            end
         end
         ST_SCB: begin
            if (mul_done) begin
               ob_in     = rnd[39:16];
               state_in  = ST_PST;
               launch_in = 1'b1;
            end
         end
         ST_PST: begin
            if (mul_done) begin
               if (post_lvl > post_ff)
                  post_in = post_lvl;
               if (gain_ff < floor_ff)
                  floor_in = gain_ff;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {floor_ff, pre_ff, post_ff, gain_ff, ob_ff, oa_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         chan_ff      <= apl_pkg::CHAN_RESET;
         ceil_ff      <= apl_pkg::CEILING_RESET;
         coeff_ff     <= apl_pkg::COEFF_RESET;
         gain_ff      <= apl_pkg::UNITY_GAIN;
         pre_ff       <= '0;
         post_ff      <= '0;
         floor_ff     <= apl_pkg::UNITY_GAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         chan_ff      <= chan_in;
         ceil_ff      <= ceil_in;
         coeff_ff     <= coeff_in;
         gain_ff      <= gain_in;
         pre_ff       <= pre_in;
         post_ff      <= post_in;
         floor_ff     <= floor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      two_ff      <= two_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      level_ff    <= level_in;
      oa_ff       <= oa_in;
      ob_ff       <= ob_in;
      rsp_data_ff <= rsp_data_in;
   end

   apl_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplr    (mul_mplr),
      .done    (mul_done),
      .product (mul_prod)
   );

   // ceiling * 2^20 / level, top bits preloaded as ceiling * 8
   apl_serial_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend_hi ({ceil_ff, 3'b000}),
      .divisor     (level_ff),
      .done        (div_done),
      .quotient    (div_q)
   );

`ifndef SYNTHESIS
   a_gain_le_unity: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= apl_pkg::UNITY_GAIN)
      else $error("gain above unity");

   a_floor_le_gain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> (floor_ff <= gain_ff))
      else $error("min gain above applied gain");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside finish");

   a_req_starts_release: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_REL && launch_ff))
      else $error("request did not start release");
`endif

endmodule

// ===== tb/audio_peak_limiter_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_peak_limiter_top_tb: self-checking bench for the audio peak limiter
// Frames go in as requests from a queue, and a local limiter model predicts
// each response: gain release, instant attack, scaled samples and meters.
// Covers the channel, ceiling and release extremes, receiver hold-off, and
// three mixes of sender and receiver idling.
// ----------------------------------------------------------------------------
module audio_peak_limiter_top_tb;

   localparam int SEGMENTS      = 18;
   localparam int SEG_FRAMES    = 97;
   localparam int RSP_HOLD      = 600;
   localparam int STALL_LIMIT   = 4000;
   localparam int TAIL_CYCLES   = 200;
   localparam int MAX_PRINTS    = 40;

   typedef struct packed {
      logic                                clr;
      logic signed [apl_pkg::SAMPLE_W-1:0] sample_b;
      logic signed [apl_pkg::SAMPLE_W-1:0] sample_a;
   } frame_type;

   // lowest bits first: out_a, out_b, applied_gain, out_peak, in_peak, min_gain
   typedef struct packed {
      logic [apl_pkg::GAIN_W-1:0]          min_gain;
      logic [apl_pkg::LEVEL_W-1:0]         in_peak;
      logic [apl_pkg::LEVEL_W-1:0]         out_peak;
      logic [apl_pkg::GAIN_W-1:0]          applied_gain;
      logic signed [apl_pkg::SAMPLE_W-1:0] out_b;
      logic signed [apl_pkg::SAMPLE_W-1:0] out_a;
   } limited_type;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [apl_pkg::REQ_W-1:0]    req_tdata  = '0;   // sample_a, sample_b
   logic [0:0]                   req_tuser  = '0;   // clear_meters
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [apl_pkg::RSP_W-1:0]    rsp_tdata;         // out_a, out_b, applied_gain,
                                                    // out_peak, in_peak, min_gain
   logic                         csr_valid  = 1'b0;
   logic                         csr_ready;
   logic [1:0]                   csr_index  = '0;
   logic [apl_pkg::COEFF_W-1:0]  csr_data   = '0;

   // limiter model state and register copies
   logic [apl_pkg::CHAN_W-1:0]   chan_cfg     = apl_pkg::CHAN_RESET;
   logic [apl_pkg::GAIN_W-1:0]   ceiling_cfg  = apl_pkg::CEILING_RESET;
   logic [apl_pkg::COEFF_W-1:0]  coeff_cfg    = apl_pkg::COEFF_RESET;
   logic [apl_pkg::GAIN_W-1:0]   gain_held    = apl_pkg::UNITY_GAIN;
   logic [apl_pkg::LEVEL_W-1:0]  post_peak    = '0;
   logic [apl_pkg::LEVEL_W-1:0]  pre_peak     = '0;
   logic [apl_pkg::GAIN_W-1:0]   gain_low     = apl_pkg::UNITY_GAIN;

   frame_type   frame_q[$];
   limited_type limited_q[$];

   int unsigned tx_idle_pct   = 7;
   int unsigned rx_idle_pct   = 85;
   int unsigned hold_requests = 0;
   int unsigned hold_seen     = 0;
   int unsigned hold_left     = 0;
   int unsigned stall_cycles  = 0;
   int unsigned mismatches    = 0;
   int unsigned frames_seen   = 0;

   audio_peak_limiter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [apl_pkg::LEVEL_W-1:0] magnitude_of(
      logic signed [apl_pkg::SAMPLE_W-1:0] x
   );
      if (!x[apl_pkg::SAMPLE_W-1])
         return x[apl_pkg::LEVEL_W-1:0];
      if (x == {1'b1, {apl_pkg::LEVEL_W{1'b0}}})
         return '1;
      return apl_pkg::LEVEL_W'(-x);
   endfunction

   // round half up: floor((x * g + 2^15) / 2^16)
   function automatic logic signed [apl_pkg::SAMPLE_W-1:0] apply_gain(
      logic signed [apl_pkg::SAMPLE_W-1:0] x,
      logic [apl_pkg::GAIN_W-1:0] g
   );
      longint p;
      p = longint'(x) * longint'({1'b0, g}) + 32768;
      return apl_pkg::SAMPLE_W'(p >>> 16);
   endfunction

   function automatic limited_type limit_frame(frame_type f);
      limited_type                 r;
      int unsigned                 nch;
      logic [apl_pkg::LEVEL_W-1:0] lvl;
      logic [apl_pkg::LEVEL_W-1:0] lvl_b;
      longint unsigned             g;
      longint unsigned             ceil_q;
      longint unsigned             post;
      nch = chan_cfg;
      if (nch < 1) nch = 1;
      if (nch > apl_pkg::MAX_CHANNELS) nch = apl_pkg::MAX_CHANNELS;
      if (nch > 2) nch = 2;
      if (f.clr) begin
         pre_peak  = '0;
         post_peak = '0;
         gain_low  = apl_pkg::UNITY_GAIN;
      end
      lvl   = magnitude_of(f.sample_a);
      lvl_b = magnitude_of(f.sample_b);
      if (nch == 2 && lvl_b > lvl) lvl = lvl_b;
      if (lvl > pre_peak) pre_peak = lvl;
      g = gain_held;
      if (g > apl_pkg::UNITY_GAIN) g = apl_pkg::UNITY_GAIN;
      g = g + (((apl_pkg::UNITY_GAIN - g) * coeff_cfg + (64'd1 << 23)) >> 24);
      ceil_q = longint'(ceiling_cfg) << 20;
      if (lvl * g > ceil_q) g = ceil_q / lvl;
      gain_held = apl_pkg::GAIN_W'(g);
      r.out_a = apply_gain(f.sample_a, apl_pkg::GAIN_W'(g));
      r.out_b = (nch == 2) ? apply_gain(f.sample_b, apl_pkg::GAIN_W'(g)) : '0;
      post = (lvl * g + 32768) >> 16;
      if (post > {apl_pkg::LEVEL_W{1'b1}}) post = {apl_pkg::LEVEL_W{1'b1}};
      if (post > post_peak) post_peak = apl_pkg::LEVEL_W'(post);
      if (g < gain_low) gain_low = apl_pkg::GAIN_W'(g);
      r.applied_gain = apl_pkg::GAIN_W'(g);
      r.out_peak     = post_peak;
      r.in_peak      = pre_peak;
      r.min_gain     = gain_low;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("[%0t] response %0d: %s", $time, frames_seen, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
      if (got_v !== want_v)
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got_v, want_v));
   endtask

   // request driver: takes a pending frame when the bus is free
   always @(posedge clock) begin : drive_frames
      frame_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            limited_q.insert(limited_q.size(),
                             limit_frame(frame_type'({req_tuser, req_tdata})));
         if (!req_tvalid || req_tready) begin
            if (frame_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               nxt = frame_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {nxt.sample_b, nxt.sample_a};
               req_tuser  <= nxt.clr;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure and long hold-offs
   always @(posedge clock) begin : watch_responses
      limited_type got;
      limited_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = limited_type'(rsp_tdata);
            if (limited_q.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = limited_q.pop_front();
               check_field("out_a", 32'(got.out_a), 32'(want.out_a));
               check_field("out_b", 32'(got.out_b), 32'(want.out_b));
               check_field("applied_gain", 32'(got.applied_gain),
                           32'(want.applied_gain));
               check_field("out_peak", 32'(got.out_peak), 32'(want.out_peak));
               check_field("in_peak", 32'(got.in_peak), 32'(want.in_peak));
               check_field("min_gain", 32'(got.min_gain), 32'(want.min_gain));
            end
            frames_seen++;
         end
         if (hold_left != 0) begin
            hold_left--;
         end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = RSP_HOLD;
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // call right after a rising edge
   task automatic write_reg(logic [1:0] idx, logic [apl_pkg::COEFF_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         apl_pkg::REG_ACTIVE_CHANNELS: chan_cfg    = val[apl_pkg::CHAN_W-1:0];
         apl_pkg::REG_CEILING:         ceiling_cfg = val[apl_pkg::GAIN_W-1:0];
         apl_pkg::REG_RELEASE_COEFF:   coeff_cfg   = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limiter(logic [apl_pkg::CHAN_W-1:0] ch,
                              logic [apl_pkg::GAIN_W-1:0] ceil_v,
                              logic [apl_pkg::COEFF_W-1:0] coeff_v);
      write_reg(apl_pkg::REG_ACTIVE_CHANNELS, apl_pkg::COEFF_W'(ch));
      write_reg(apl_pkg::REG_CEILING, apl_pkg::COEFF_W'(ceil_v));
      write_reg(apl_pkg::REG_RELEASE_COEFF, coeff_v);
   endtask

   task automatic drain_all();
      while (!(frame_q.size() == 0 && !req_tvalid && limited_q.size() == 0))
         @(posedge clock);
   endtask

   task automatic push_frame(logic signed [apl_pkg::SAMPLE_W-1:0] a,
                             logic signed [apl_pkg::SAMPLE_W-1:0] b,
                             logic clr);
      frame_type f;
      f.sample_a = a;
      f.sample_b = b;
      f.clr      = clr;
      frame_q.insert(frame_q.size(), f);
   endtask

   function automatic logic signed [apl_pkg::SAMPLE_W-1:0] audio_sample(bit loud);
      int unsigned amp;
      case ($urandom_range(15))
         0: return apl_pkg::SAMPLE_W'($urandom());
         1: begin
            case ($urandom_range(4))
               0: return 24'sh7FFFFF;
               1: return 24'sh800000;
               2: return '0;
               3: return 24'sd1;
               default: return '1;
            endcase
         end
         default: amp = loud ? $urandom_range(8388607, 2000000) : $urandom_range(1500000);
      endcase
      return $urandom_range(1) ? apl_pkg::SAMPLE_W'(amp) : -apl_pkg::SAMPLE_W'(amp);
   endfunction

   function automatic logic [apl_pkg::GAIN_W-1:0] pick_ceiling();
      case ($urandom_range(9))
         0: return '0;
         1: return apl_pkg::GAIN_W'(1);
         2: return apl_pkg::UNITY_GAIN;
         3: return apl_pkg::GAIN_W'($urandom_range(131071));
         4: return apl_pkg::GAIN_W'($urandom_range(131071, 65537));
         default: return apl_pkg::GAIN_W'($urandom_range(65535, 8192));
      endcase
   endfunction

   function automatic logic [apl_pkg::COEFF_W-1:0] pick_coeff();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return apl_pkg::COEFF_W'($urandom());
         default: return apl_pkg::COEFF_W'($urandom_range(200000, 1));
      endcase
   endfunction

   initial begin
      logic [apl_pkg::CHAN_W-1:0] ch;
      int unsigned                burst;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: two channels, ceiling 0.9, default release
      push_frame('0, '0, 1'b1);
      push_frame(24'sh7FFFFF, '0, 1'b0);
      push_frame(24'sh800000, 24'sh800000, 1'b0);
      push_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
      push_frame(24'sd1, -24'sd1, 1'b0);
      push_frame('0, '0, 1'b0);
      push_frame(24'sh400000, -24'sh123456, 1'b1);
      drain_all();

      // one channel: sample_b must not count
      set_limiter(2'd1, apl_pkg::CEILING_RESET, apl_pkg::COEFF_RESET);
      push_frame(24'sd100000, 24'sh800000, 1'b0);
      push_frame(24'sh800000, 24'sh7FFFFF, 1'b1);
      drain_all();
      write_reg(apl_pkg::REG_ACTIVE_CHANNELS, apl_pkg::COEFF_W'(0));
      push_frame(-24'sd5000000, 24'sh7FFFFF, 1'b0);
      drain_all();

      // channel count saturates, ceiling zero silences
      set_limiter(2'd3, '0, apl_pkg::COEFF_RESET);
      push_frame(24'sh7FFFFF, 24'sd1, 1'b0);
      push_frame('0, '0, 1'b0);
      push_frame(-24'sd1, 24'sd1, 1'b1);
      drain_all();

      // ceiling above unity, full release
      set_limiter(2'd2, 17'h1FFFF, '1);
      push_frame(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
      push_frame(24'sh800000, '0, 1'b0);
      drain_all();

      // smallest ceiling, no release
      set_limiter(2'd2, 17'd1, '0);
      push_frame(24'sh7FFFFF, 24'sh800000, 1'b1);
      push_frame(24'sd4, -24'sd4, 1'b0);
      push_frame('0, '0, 1'b0);
      drain_all();
      write_reg(apl_pkg::REG_CEILING, apl_pkg::COEFF_W'(apl_pkg::UNITY_GAIN));
      push_frame(24'sh7FFFFF, '0, 1'b1);
      push_frame(24'sh800000, 24'sh2AAAAA, 1'b0);
      drain_all();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 6)
            0: begin tx_idle_pct = 7;  rx_idle_pct = 85; end
            1: begin tx_idle_pct = 85; rx_idle_pct = 7;  end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         case ($urandom_range(9))
            0: ch = 2'd0;
            1: ch = 2'd3;
            2, 3, 4: ch = 2'd1;
            default: ch = 2'd2;
         endcase
         set_limiter(ch, pick_ceiling(), pick_coeff());
         burst = 3 + $urandom_range(8);
         for (int i = 0; i < SEG_FRAMES; i++)
            push_frame(audio_sample(((i / burst) % 3) == 0),
                       audio_sample(((i / burst) % 3) == 0),
                       $urandom_range(31) == 0);
         // receiver stalls while requests keep coming
         if (seg == 2 || seg == 13)
            hold_requests++;
         drain_all();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
